>>> sv/xsr_pkg.sv
`default_nettype none

package xsr_pkg;

    localparam int WORD_W  = 64;
    localparam int BOUND_W = 63;
    localparam int HALF_W  = WORD_W / 2;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    localparam logic [1:0] OP_RESEED  = 2'd0;
    localparam logic [1:0] OP_RAW     = 2'd1;
    localparam logic [1:0] OP_BOUNDED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_ADD,
        S_MIX_MUL,
        S_MIX_XS,
        S_MIX_STORE,
        S_DRAW_MUL,
        S_DRAW_ROT,
        S_DIV,
        S_HOLD
    } t_state;

endpackage

`default_nettype wire

>>> sv/xoshiro256ss_random_generator.sv
// xoshiro256** random generator with splitmix64 seeding.
// Request channel: i_valid / o_stall carrying i_op and i_bound. A request is
// taken when i_valid is high and o_stall is low; o_stall is high while a
// request is being worked on, so one request is in flight at a time.
// Result channel: o_valid / i_stall carrying o_value and o_error. The result
// sits in an output register until taken; a new request is accepted while it
// waits, and a finished result waits in the sequencer if the register is full.
// Seed register: i_seed_we / i_seed_value, to be written by the user only
// while the block is idle; the block itself does not enforce this. A bounded
// draw runs a restoring divider that gives one remainder bit per cycle; a
// reseed runs four splitmix64 steps, each multiply done as three passes
// through one 32x32 multiplier; a zero bound or unused op goes to S_HOLD.
// A request may be accepted on the cycle after its result is loaded; a new
// request is not taken before the last one has finished.
// After reset the state is expanded from seed zero with the same splitmix64
// sequencer; during this o_stall is high and no result is produced. Seed
// writes are taken as ever during that time.
// While the receiver stalls, o_valid and the result fields hold.

`default_nettype none

module xoshiro256ss_random_generator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_seed_we,
    input  wire logic [xsr_pkg::WORD_W-1:0]  i_seed_value,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_op,
    input  wire logic [xsr_pkg::BOUND_W-1:0] i_bound,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [xsr_pkg::WORD_W-1:0]      o_value,
    output logic                            o_error
);
    import xsr_pkg::*;

    t_state              r_state, n_state;
    logic [1:0]          r_idx, n_idx;
    logic [1:0]          r_phase, n_phase;
    logic                r_mix_b, n_mix_b;
    logic                r_init, n_init;
    logic [WORD_W-1:0]   r_seed;
    logic [WORD_W-1:0]   r_ctr, n_ctr;
    logic [WORD_W-1:0]   r_z, n_z;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic [WORD_W-1:0]   r_w [4];
    logic [WORD_W-1:0]   n_w [4];
    logic [1:0]          r_op, n_op;
    logic [BOUND_W-1:0]  r_bound, n_bound;
    logic [WORD_W-1:0]   r_res, n_res;
    logic                r_err, n_err;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [5:0]          r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_value, n_out_value;
    logic                r_out_error, n_out_error;

    logic [WORD_W-1:0]   ctr_sum;
    logic [WORD_W-1:0]   mul_c;
    logic [HALF_W-1:0]   mul_x, mul_y;
    logic [WORD_W-1:0]   mul_p;
    logic [WORD_W-1:0]   rot;
    logic [WORD_W-1:0]   rem_sh;
    logic [WORD_W-1:0]   bound_ext;
    logic                rem_ge;
    logic [WORD_W-1:0]   rem_next;
    logic [WORD_W-1:0]   t2, t3;
    logic                out_free;

    // shared datapath pieces
    assign ctr_sum   = r_ctr + GOLDEN_GAMMA;
    assign mul_c     = r_mix_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_x     = (r_phase == 2'd2) ? r_z[WORD_W-1:HALF_W] : r_z[HALF_W-1:0];
    assign mul_y     = (r_phase == 2'd1) ? mul_c[WORD_W-1:HALF_W] : mul_c[HALF_W-1:0];
    assign mul_p     = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
    assign rot       = {r_z[WORD_W-8:0], r_z[WORD_W-1:WORD_W-7]};
    assign bound_ext = {1'b0, r_bound};
    assign rem_sh    = {r_rem[WORD_W-2:0], r_res[WORD_W-1]};
    assign rem_ge    = rem_sh >= bound_ext;
    assign rem_next  = rem_ge ? (rem_sh - bound_ext) : rem_sh;
    assign t2        = r_w[2] ^ r_w[0];
    assign t3        = r_w[3] ^ r_w[1];
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_mix_b     = r_mix_b;
        n_init      = r_init;
        n_ctr       = r_ctr;
        n_z         = r_z;
        n_acc       = r_acc;
        n_w         = r_w;
        n_op        = r_op;
        n_bound     = r_bound;
        n_res       = r_res;
        n_err       = r_err;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_error = r_out_error;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_op;
                    n_bound = i_bound;
                    n_res   = '0;
                    n_err   = 1'b0;
                    unique case (i_op)
                        OP_RESEED: begin
                            n_ctr   = r_seed;
                            n_idx   = 2'd0;
                            n_state = S_MIX_ADD;
                        end
                        OP_RAW: begin
                            n_state = S_DRAW_MUL;
                        end
                        OP_BOUNDED: begin
                            if (i_bound == '0) begin
                                n_err   = 1'b1;
                                n_state = S_HOLD;
                            end else begin
                                n_state = S_DRAW_MUL;
                            end
                        end
                        default: begin
                            n_state = S_HOLD;
                        end
                    endcase
                end
            end
            S_MIX_ADD: begin
                n_ctr   = ctr_sum;
                n_z     = ctr_sum ^ (ctr_sum >> 30);
                n_phase = 2'd0;
                n_mix_b = 1'b0;
                n_state = S_MIX_MUL;
            end
            S_MIX_MUL: begin
                // low 64 bits of a 64x64 product in three 32x32 passes
                if (r_phase == 2'd0) begin
                    n_acc = mul_p;
                end else begin
                    n_acc = r_acc + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
                end
                n_phase = r_phase + 2'd1;
                if (r_phase == 2'd2) begin
                    n_phase = 2'd0;
                    n_state = r_mix_b ? S_MIX_STORE : S_MIX_XS;
                end
            end
            S_MIX_XS: begin
                n_z     = r_acc ^ (r_acc >> 27);
                n_mix_b = 1'b1;
                n_state = S_MIX_MUL;
            end
            S_MIX_STORE: begin
                n_w[r_idx] = r_acc ^ (r_acc >> 31);
                n_idx      = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_HOLD;
                end else begin
                    n_state = S_MIX_ADD;
                end
            end
            S_DRAW_MUL: begin
                n_z     = r_w[1] + (r_w[1] << 2);
                n_state = S_DRAW_ROT;
            end
            S_DRAW_ROT: begin
                n_res  = rot + (rot << 3);
                n_w[0] = r_w[0] ^ t3;
                n_w[1] = r_w[1] ^ t2;
                n_w[2] = t2 ^ (r_w[1] << 17);
                n_w[3] = {t3[WORD_W-46:0], t3[WORD_W-1:WORD_W-45]};
                if (r_op == OP_BOUNDED) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_DIV: begin
                n_rem = rem_next;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_res   = rem_next;
                    n_state = S_HOLD;
                end else begin
                    n_res = r_res << 1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_out_error = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_MIX_ADD;
            r_idx       <= 2'd0;
            r_phase     <= 2'd0;
            r_mix_b     <= 1'b0;
            r_init      <= 1'b1;
            r_ctr       <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_phase     <= n_phase;
            r_mix_b     <= n_mix_b;
            r_init      <= n_init;
            r_ctr       <= n_ctr;
            r_out_valid <= n_out_valid;
            if (i_seed_we) begin
                r_seed <= i_seed_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_z         <= n_z;
        r_acc       <= n_acc;
        r_w         <= n_w;
        r_op        <= n_op;
        r_bound     <= n_bound;
        r_res       <= n_res;
        r_err       <= n_err;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_out_value <= n_out_value;
        r_out_error <= n_out_error;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

    a_load_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result loaded outside the hold state");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_error) |-> (r_out_value == '0))
        else $error("error result carries a nonzero value");

    a_rem_below_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < bound_ext))
        else $error("partial remainder not below bound");

    a_reset_seeds: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (r_state == S_MIX_ADD && r_init && !r_out_valid))
        else $error("reset did not start seed expansion");

endmodule

`default_nettype wire
